/* design/tsfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfr_pkg
// Shared constants, codes, types and helpers of the text find/replace block.
// ----------------------------------------------------------------------------
package tsfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int COUNT_WIDTH_DEF     = 32;

  localparam int MODE_W  = 3;
  localparam int INDEX_W = 3;
  localparam int LEN_W   = 4;
  localparam int TEXT_W  = 64;
  localparam int OUT_COUNT_W = 32;

  localparam logic [MODE_W-1:0] MODE_LENGTH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WORDS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LINES   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd4;

  localparam logic [INDEX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [INDEX_W-1:0] REG_PAT      = 3'd1;
  localparam logic [INDEX_W-1:0] REG_PAT_LEN  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_REPL     = 3'd3;
  localparam logic [INDEX_W-1:0] REG_REPL_LEN = 3'd4;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef struct packed {
    logic              check;
    logic              hit;
    logic [LEN_W-1:0]  win_cnt;
    logic [TEXT_W-1:0] win_bytes;
  } match_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

/* design/text_stream_find_replace.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_stream_find_replace
// Streaming byte/word/line/match counter and pattern replacer.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle whenever it yields at most one result beat
// and out_stall is low. A byte that yields more (a replacement, or the window
// flush and the final count on the last byte) yields up to nine beats, queued
// in a pending buffer that drains one per cycle into the output register
// unless stalled; the input is stalled until the buffer is down to its last
// beat. Matching compares the whole pattern window in the cycle the byte is
// taken. Configuration writes are always ready and restart the text.
module text_stream_find_replace #(
  parameter int MAX_PATTERN     = tsfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = tsfr_pkg::MAX_REPLACEMENT_DEF,
  parameter int COUNT_WIDTH     = tsfr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsfr_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [tsfr_pkg::TEXT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    text_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          has_byte,
  output logic [7:0]                    out_byte,
  output logic [tsfr_pkg::OUT_COUNT_W-1:0] count,
  output logic                          status,
  output logic                          last_result
);

  localparam int LW = tsfr_pkg::LEN_W;

  logic [tsfr_pkg::MODE_W-1:0] mode;
  logic [tsfr_pkg::TEXT_W-1:0] pattern_bytes;
  logic [LW-1:0]               pattern_len;
  logic [tsfr_pkg::TEXT_W-1:0] replacement_bytes;
  logic [LW-1:0]               replacement_len;

  logic [COUNT_WIDTH-1:0] run_count;
  logic                   inside_word;

  logic [tsfr_pkg::TEXT_W-1:0]      pend_bytes;
  logic [LW-1:0]                    pend_cnt;
  logic                             pend_final;
  logic [tsfr_pkg::OUT_COUNT_W-1:0] pend_count;
  logic                             pend_status;

  logic [tsfr_pkg::MODE_W-1:0] mode_eff;
  logic [LW-1:0]               plen;
  logic [LW-1:0]               rlen;
  logic                        find_mode;
  logic                        cfg_clear;
  logic                        accept;
  logic                        out_free;
  logic                        bump;
  logic [COUNT_WIDTH-1:0]      count_next;
  logic [COUNT_WIDTH-1:0]      final_count;
  logic                        inside_next;
  tsfr_pkg::match_t            mres;

  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid && cfg_index <= tsfr_pkg::REG_REPL_LEN;

  assign mode_eff  = (mode > tsfr_pkg::MODE_REPLACE) ? tsfr_pkg::MODE_LENGTH : mode;
  assign plen      = (pattern_len > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : pattern_len;
  assign rlen      = (replacement_len > LW'(MAX_REPLACEMENT)) ? LW'(MAX_REPLACEMENT)
                                                              : replacement_len;
  assign find_mode = mode_eff == tsfr_pkg::MODE_COUNT || mode_eff == tsfr_pkg::MODE_REPLACE;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((pend_cnt == '0 && !pend_final) ||
                      (out_free && ((pend_cnt == LW'(1) && !pend_final) ||
                                    (pend_cnt == '0 && pend_final))));
  assign accept   = in_valid && !in_stall;

  tsfr_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_clear || (accept && last_byte)),
    .step         (accept && find_mode && plen != '0),
    .last_byte    (last_byte),
    .text_byte    (text_byte),
    .pattern_bytes(pattern_bytes),
    .plen         (plen),
    .res          (mres)
  );

  always_comb begin
    bump        = 1'b0;
    inside_next = inside_word;
    case (mode_eff)
      tsfr_pkg::MODE_LENGTH: bump = 1'b1;
      tsfr_pkg::MODE_WORDS: begin
        bump        = !tsfr_pkg::is_space(text_byte) && !inside_word;
        inside_next = !tsfr_pkg::is_space(text_byte);
      end
      tsfr_pkg::MODE_LINES: bump = text_byte == tsfr_pkg::NEWLINE;
      tsfr_pkg::MODE_COUNT,
      tsfr_pkg::MODE_REPLACE: bump = plen != '0 && mres.hit;
      default: bump = 1'b0;
    endcase
  end

  always_comb begin
    count_next = run_count;
    if (bump && run_count != '1) begin
      count_next = run_count + COUNT_WIDTH'(1);
    end
    if (find_mode && plen == '0) begin
      final_count = '0;
    end else if (mode_eff == tsfr_pkg::MODE_LINES && count_next != '1) begin
      final_count = count_next + COUNT_WIDTH'(1);
    end else begin
      final_count = count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= tsfr_pkg::MODE_LENGTH;
      pattern_bytes     <= '0;
      pattern_len       <= '0;
      replacement_bytes <= '0;
      replacement_len   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsfr_pkg::REG_MODE:     mode              <= cfg_data[tsfr_pkg::MODE_W-1:0];
        tsfr_pkg::REG_PAT:      pattern_bytes     <= cfg_data;
        tsfr_pkg::REG_PAT_LEN:  pattern_len       <= cfg_data[LW-1:0];
        tsfr_pkg::REG_REPL:     replacement_bytes <= cfg_data;
        tsfr_pkg::REG_REPL_LEN: replacement_len   <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      run_count   <= '0;
      inside_word <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        run_count   <= '0;
        inside_word <= 1'b0;
      end else begin
        run_count   <= count_next;
        inside_word <= inside_next;
      end
    end
  end

  // result beats: bytes first, then the final count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_cnt   <= '0;
      pend_final <= 1'b0;
    end else begin
      if (out_free) begin
        if (pend_cnt != '0) begin
          out_valid   <= 1'b1;
          has_byte    <= 1'b1;
          out_byte    <= pend_bytes[7:0];
          count       <= '0;
          status      <= 1'b0;
          last_result <= 1'b0;
        end else if (pend_final) begin
          out_valid   <= 1'b1;
          has_byte    <= 1'b0;
          out_byte    <= '0;
          count       <= pend_count;
          status      <= pend_status;
          last_result <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end
      if (accept) begin
        pend_final  <= last_byte;
        pend_count  <= tsfr_pkg::OUT_COUNT_W'(final_count);
        pend_status <= find_mode && plen == '0;
        if (mode_eff == tsfr_pkg::MODE_REPLACE && plen != '0) begin
          if (mres.hit) begin
            pend_bytes <= replacement_bytes;
            pend_cnt   <= rlen;
          end else begin
            pend_bytes <= mres.win_bytes;
            pend_cnt   <= mres.win_cnt;
          end
        end else begin
          pend_cnt <= '0;
        end
      end else if (out_free) begin
        if (pend_cnt != '0) begin
          pend_bytes <= pend_bytes >> 8;
          pend_cnt   <= pend_cnt - LW'(1);
        end else if (pend_final) begin
          pend_final <= 1'b0;
        end
      end
    end
  end

  a_last_queues_final: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> pend_final)
    else $error("last byte did not queue a final beat");

  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> run_count == '0)
    else $error("count not cleared after last byte");

  a_burst_stalls: assert property (@(posedge clk) disable iff (rst)
    pend_cnt > LW'(1) |-> in_stall)
    else $error("input taken while a burst is pending");

  a_status_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last_result && !has_byte)
    else $error("error status on a byte beat");

endmodule

/* design/tsfr_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfr_match
// Pending-byte window and parallel pattern compare for find and replace.
// ----------------------------------------------------------------------------
module tsfr_match #(
  parameter int MAX_PATTERN = tsfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         step,
  input  logic                         last_byte,
  input  logic [7:0]                   text_byte,
  input  logic [tsfr_pkg::TEXT_W-1:0]  pattern_bytes,
  input  logic [tsfr_pkg::LEN_W-1:0]   plen,
  output tsfr_pkg::match_t             res
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int WIN_W  = MAX_PATTERN * 8;

  logic [WIN_W-1:0]  window;
  logic [FILL_W-1:0] fill;
  logic [WIN_W-1:0]  win_ins;
  logic [FILL_W-1:0] fill_ins;
  logic              mismatch;
  logic              check;

  always_comb begin
    win_ins = window;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (fill == FILL_W'(i)) begin
        win_ins[i*8 +: 8] = text_byte;
      end
    end
  end

  assign fill_ins = fill + FILL_W'(1);
  assign check    = tsfr_pkg::LEN_W'(fill_ins) >= plen;

  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (tsfr_pkg::LEN_W'(i) < plen && win_ins[i*8 +: 8] != pattern_bytes[i*8 +: 8]) begin
        mismatch = 1'b1;
      end
    end
  end

  always_comb begin
    res.check     = check;
    res.hit       = check && !mismatch;
    res.win_bytes = tsfr_pkg::TEXT_W'(win_ins);
    if (last_byte) begin
      res.win_cnt = tsfr_pkg::LEN_W'(fill_ins);
    end else if (check) begin
      res.win_cnt = tsfr_pkg::LEN_W'(1);
    end else begin
      res.win_cnt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
    end else if (step) begin
      if (check && !mismatch) begin
        fill <= '0;
      end else if (check) begin
        window <= win_ins >> 8;
        fill   <= fill_ins - FILL_W'(1);
      end else begin
        window <= win_ins;
        fill   <= fill_ins;
      end
    end
  end

endmodule
